/* rtl/core/kdj_pkg.sv */
// kdj_pkg: shared types and fixed constants for the kdj oscillator core
// used by kdj_cell, kdj_div and stochastic_kdj_oscillator_core; no dependencies
package kdj_pkg;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int WLEN_W = 6;
    localparam int SMOOTH_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_K_SMOOTHING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_D_SMOOTHING = 2'd2;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 6'd9;
    localparam logic [SMOOTH_W-1:0] K_SMOOTH_RESET = 8'd3;
    localparam logic [SMOOTH_W-1:0] D_SMOOTH_RESET = 8'd3;

    // window cell control: load from the younger-side neighbor or rotate toward cell 0
    typedef struct packed {
        logic shift_in;
        logic rotate;
    } cell_ctrl_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/core/stochastic_kdj_oscillator_core.sv */
// stochastic_kdj_oscillator_core: KDJ oscillator with a rotating chain of window cells
// depends on kdj_pkg, kdj_cell, kdj_div
//
// Usage:
//   Input channel (in_valid/in_ready) carries one price bar: start_series, price_high,
//   price_low, price_close. Output channel (out_valid/out_ready) carries one result per
//   bar: k_value, d_value and the two's complement j_value, scaled by 2**FRAC_BITS.
//   Configuration is a plain write port (cfg_write, cfg_index, cfg_data) with no
//   read-back; write only while the core is idle. Unknown indexes are ignored.
//   One bar is worked at a time. After a transfer the bar is shifted into the cell
//   chain, then the chain rotates a full turn while cell 0 feeds the lowest-low /
//   highest-high compare. Three divisions share one restoring divider at one bit per
//   cycle. A flat or saturated window saves one division and the first bar of a
//   series saves the two smoothing divisions. in_ready is high only between bars.
//   Results wait in an output register; if the receiver stalls, the next bar may
//   still be taken and is held at its last step until the output register frees up.
//   Reset clears the series, K and D, and loads the register defaults (9, 3, 3).
module stochastic_kdj_oscillator_core #(
    parameter int WINDOW_MAX = 32,
    parameter int PRICE_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              start_series,
    input  logic [PRICE_BITS-1:0]             price_high,
    input  logic [PRICE_BITS-1:0]             price_low,
    input  logic [PRICE_BITS-1:0]             price_close,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [FRAC_BITS+6:0]              k_value,
    output logic [FRAC_BITS+6:0]              d_value,
    output logic signed [FRAC_BITS+9:0]       j_value,
    input  logic                              cfg_write,
    input  logic [kdj_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kdj_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import kdj_pkg::*;

    localparam int P = PRICE_BITS;
    localparam int N = WINDOW_MAX;
    localparam int VAL_W = FRAC_BITS + 7;
    localparam int J_W = FRAC_BITS + 10;
    localparam int NUM_W = P + 7;
    localparam int DVD_W = P + VAL_W;
    localparam int SMN_W = SMOOTH_W + VAL_W;
    localparam int LW = $clog2(N + 1);
    localparam int CW = (N > 1) ? $clog2(N) : 1;

    localparam logic [VAL_W-1:0] FULL_SCALE = VAL_W'(100 * (2 ** FRAC_BITS));
    localparam logic [VAL_W-1:0] HALF_SCALE = VAL_W'(50 * (2 ** FRAC_BITS));

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_PREP  = 4'd2;
    localparam logic [3:0] S_RSV   = 4'd3;
    localparam logic [3:0] S_RWAIT = 4'd4;
    localparam logic [3:0] S_KMUL  = 4'd5;
    localparam logic [3:0] S_KGO   = 4'd6;
    localparam logic [3:0] S_KWAIT = 4'd7;
    localparam logic [3:0] S_DMUL  = 4'd8;
    localparam logic [3:0] S_DGO   = 4'd9;
    localparam logic [3:0] S_DWAIT = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    // configuration
    logic [WLEN_W-1:0]   window_length_reg;
    logic [SMOOTH_W-1:0] k_smoothing_reg;
    logic [SMOOTH_W-1:0] d_smoothing_reg;

    // control
    logic [3:0]    state_reg;
    logic [3:0]    state_next;
    logic [LW-1:0] bars_held_reg;
    logic [LW-1:0] bars_next;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic [LW-1:0] wlen_eff;
    logic [CW-1:0] scan_cnt_reg;
    logic          first_reg;
    logic          out_valid_reg;

    // datapath
    logic [P-1:0]     lo_reg;
    logic [P-1:0]     hi_reg;
    logic [P-1:0]     close_reg;
    logic [NUM_W-1:0] num_reg;
    logic [P-1:0]     den_reg;
    logic             flat_reg;
    logic             below_reg;
    logic             above_reg;
    logic [VAL_W-1:0] rsv_reg;
    logic [SMN_W-1:0] smooth_num_reg;
    logic [VAL_W-1:0] k_line_reg;
    logic [VAL_W-1:0] d_line_reg;
    logic [VAL_W-1:0] k_out_reg;
    logic [VAL_W-1:0] d_out_reg;
    logic [J_W-1:0]   j_out_reg;
    logic [J_W-1:0]   j_next;

    logic [SMOOTH_W-1:0] kf_eff;
    logic [SMOOTH_W-1:0] df_eff;
    logic                accept;
    logic                special;
    logic                out_load;

    // cell chain
    cell_ctrl_t   cell_ctrl;
    logic [P-1:0] cell_high [N];
    logic [P-1:0] cell_low [N];

    // divider
    logic             div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [P-1:0]     div_divisor;
    logic [VAL_W-1:0] div_quotient;
    div_stat_t        div_stat;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign special  = flat_reg || below_reg || above_reg;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign kf_eff   = (k_smoothing_reg == '0) ? SMOOTH_W'(1) : k_smoothing_reg;
    assign df_eff   = (d_smoothing_reg == '0) ? SMOOTH_W'(1) : d_smoothing_reg;

    assign cell_ctrl.shift_in = accept;
    assign cell_ctrl.rotate   = (state_reg == S_SCAN);

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            logic [P-1:0] prev_h;
            logic [P-1:0] prev_l;
            logic [P-1:0] next_h;
            logic [P-1:0] next_l;

            if (gi == 0)
            begin : g_head
                assign prev_h = price_high;
                assign prev_l = price_low;
            end
            else
            begin : g_body
                assign prev_h = cell_high[gi-1];
                assign prev_l = cell_low[gi-1];
            end

            // the head wraps to the oldest cell so a full turn restores the order
            if (gi == N - 1)
            begin : g_tail
                assign next_h = cell_high[0];
                assign next_l = cell_low[0];
            end
            else
            begin : g_mid
                assign next_h = cell_high[gi+1];
                assign next_l = cell_low[gi+1];
            end

            kdj_cell #(
                .W(P)
            ) u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl),
                .prev_high (prev_h),
                .prev_low  (prev_l),
                .next_high (next_h),
                .next_low  (next_l),
                .high      (cell_high[gi]),
                .low       (cell_low[gi])
            );
        end
    endgenerate

    assign div_start = ((state_reg == S_RSV) && !special) || (state_reg == S_KGO) ||
                       (state_reg == S_DGO);

    always_comb
    begin
        div_dividend = DVD_W'(smooth_num_reg);
        div_divisor  = P'(df_eff);
        case (state_reg)
            S_RSV:
            begin
                div_dividend = {num_reg, {FRAC_BITS{1'b0}}};
                div_divisor  = den_reg;
            end
            S_KGO:
            begin
                div_divisor = P'(kf_eff);
            end
            default:
            begin
                div_divisor = P'(df_eff);
            end
        endcase
    end

    kdj_div #(
        .DIVW(P),
        .QW  (VAL_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    // series length and effective window for the bar being taken
    always_comb
    begin
        if (start_series)
            bars_next = LW'(1);
        else if (bars_held_reg == LW'(N))
            bars_next = bars_held_reg;
        else
            bars_next = bars_held_reg + 1'b1;

        if (window_length_reg == '0)
            wlen_eff = LW'(1);
        else if (32'(window_length_reg) > N)
            wlen_eff = LW'(N);
        else
            wlen_eff = LW'(window_length_reg);

        len_next = (wlen_eff > bars_next) ? bars_next : wlen_eff;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_cnt_reg == CW'(N - 1))
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                state_next = S_RSV;
            end
            S_RSV:
            begin
                state_next = special ? S_KMUL : S_RWAIT;
            end
            S_RWAIT:
            begin
                if (div_stat.done)
                    state_next = S_KMUL;
            end
            S_KMUL:
            begin
                state_next = first_reg ? S_DONE : S_KGO;
            end
            S_KGO:
            begin
                state_next = S_KWAIT;
            end
            S_KWAIT:
            begin
                if (div_stat.done)
                    state_next = S_DMUL;
            end
            S_DMUL:
            begin
                state_next = S_DGO;
            end
            S_DGO:
            begin
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_stat.done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign j_next = J_W'(k_line_reg) + J_W'({k_line_reg, 1'b0}) - J_W'({d_line_reg, 1'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WLEN_RESET;
            k_smoothing_reg   <= K_SMOOTH_RESET;
            d_smoothing_reg   <= D_SMOOTH_RESET;
            state_reg         <= S_IDLE;
            bars_held_reg     <= '0;
            len_reg           <= '0;
            scan_cnt_reg      <= '0;
            first_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
            k_line_reg        <= '0;
            d_line_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_WINDOW_LENGTH: window_length_reg <= cfg_data[WLEN_W-1:0];
                    REG_K_SMOOTHING:   k_smoothing_reg <= cfg_data[SMOOTH_W-1:0];
                    REG_D_SMOOTHING:   d_smoothing_reg <= cfg_data[SMOOTH_W-1:0];
                    default:           ;
                endcase
            end

            if (accept)
            begin
                first_reg     <= start_series || (bars_held_reg == '0);
                bars_held_reg <= bars_next;
                len_reg       <= len_next;
                scan_cnt_reg  <= '0;
            end
            else if (state_reg == S_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end

            if (state_reg == S_KMUL && first_reg)
            begin
                k_line_reg <= rsv_reg;
                d_line_reg <= rsv_reg;
            end
            if (state_reg == S_KWAIT && div_stat.done)
                k_line_reg <= div_quotient;
            if (state_reg == S_DWAIT && div_stat.done)
                d_line_reg <= div_quotient;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lo_reg    <= price_low;
            hi_reg    <= price_high;
            close_reg <= price_close;
        end
        else if (state_reg == S_SCAN && LW'(scan_cnt_reg) < len_reg)
        begin
            // cell 0 holds the bar of age scan_cnt_reg during the turn
            if (cell_low[0] < lo_reg)
                lo_reg <= cell_low[0];
            if (cell_high[0] > hi_reg)
                hi_reg <= cell_high[0];
        end

        if (state_reg == S_PREP)
        begin
            num_reg   <= NUM_W'(close_reg - lo_reg) * NUM_W'(100);
            den_reg   <= hi_reg - lo_reg;
            flat_reg  <= (hi_reg <= lo_reg);
            below_reg <= (close_reg <= lo_reg);
            above_reg <= (close_reg >= hi_reg);
        end

        if (state_reg == S_RSV)
        begin
            if (flat_reg)
                rsv_reg <= HALF_SCALE;
            else if (below_reg)
                rsv_reg <= '0;
            else if (above_reg)
                rsv_reg <= FULL_SCALE;
        end
        else if (state_reg == S_RWAIT && div_stat.done)
        begin
            rsv_reg <= (div_quotient > FULL_SCALE) ? FULL_SCALE : div_quotient;
        end

        if (state_reg == S_KMUL)
            smooth_num_reg <= SMN_W'(kf_eff - 1'b1) * SMN_W'(k_line_reg) + SMN_W'(rsv_reg);
        else if (state_reg == S_DMUL)
            smooth_num_reg <= SMN_W'(df_eff - 1'b1) * SMN_W'(d_line_reg) + SMN_W'(k_line_reg);

        if (out_load)
        begin
            k_out_reg <= k_line_reg;
            d_out_reg <= d_line_reg;
            j_out_reg <= j_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign k_value   = k_out_reg;
    assign d_value   = d_out_reg;
    assign j_value   = $signed(j_out_reg);

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_RWAIT || state_reg == S_KWAIT ||
                           state_reg == S_DWAIT))
        else $error("divider result arrived outside a wait state");

    a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> (len_reg != '0 && len_reg <= bars_held_reg))
        else $error("search length outside the held bars");

    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_line_reg <= FULL_SCALE && d_line_reg <= FULL_SCALE)
        else $error("smoothed line above full scale");

endmodule

/* rtl/core/kdj_cell.sv */
// kdj_cell: one window cell holding the high and low of one bar
// depends on kdj_pkg (cell_ctrl_t)
module kdj_cell #(
    parameter int W = 32
) (
    input  logic                clk,
    input  kdj_pkg::cell_ctrl_t ctrl,
    input  logic [W-1:0]        prev_high,
    input  logic [W-1:0]        prev_low,
    input  logic [W-1:0]        next_high,
    input  logic [W-1:0]        next_low,
    output logic [W-1:0]        high,
    output logic [W-1:0]        low
);
    import kdj_pkg::*;

    logic [W-1:0] high_reg;
    logic [W-1:0] low_reg;

    // insert moves bars one cell older, rotate moves them one cell back toward cell 0
    always_ff @(posedge clk)
    begin
        if (ctrl.shift_in)
        begin
            high_reg <= prev_high;
            low_reg  <= prev_low;
        end
        else if (ctrl.rotate)
        begin
            high_reg <= next_high;
            low_reg  <= next_low;
        end
    end

    assign high = high_reg;
    assign low  = low_reg;

endmodule

/* rtl/core/kdj_div.sv */
// kdj_div: restoring divider, one quotient bit per cycle
// depends on kdj_pkg (div_stat_t); caller guarantees dividend >> QW < divisor
module kdj_div #(
    parameter int DIVW = 32,
    parameter int QW = 23
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIVW+QW-1:0] dividend,
    input  logic [DIVW-1:0]    divisor,
    output logic [QW-1:0]      quotient,
    output kdj_pkg::div_stat_t stat
);
    import kdj_pkg::*;

    localparam int QCW = (QW > 1) ? $clog2(QW) : 1;

    logic [DIVW-1:0] rem_reg;
    logic [QW-1:0]   bits_reg;
    logic [DIVW-1:0] dsr_reg;
    logic [QCW-1:0]  cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [DIVW:0]   trial;
    logic [DIVW:0]   diff;
    logic            ge;

    assign trial = {rem_reg, bits_reg[QW-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == QCW'(QW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend bits leave at the top of bits_reg while quotient bits enter at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend[DIVW+QW-1:QW];
            bits_reg <= dividend[QW-1:0];
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[DIVW-1:0] : trial[DIVW-1:0];
            bits_reg <= {bits_reg[QW-2:0], ge};
        end
    end

    assign quotient  = bits_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* tb/kdj_checker.sv */
// kdj_checker: watches the bar and result channels of the kdj oscillator core,
// predicts k, d and j for every bar transfer and compares them in order
// depends on kdj_pkg for the register indexes, widths and reset values
`timescale 1ns / 1ps

module kdj_checker #(
    parameter int WINDOW_MAX = 32,
    parameter int PRICE_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           start_series,
    input  logic [PRICE_BITS-1:0]          price_high,
    input  logic [PRICE_BITS-1:0]          price_low,
    input  logic [PRICE_BITS-1:0]          price_close,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [FRAC_BITS+6:0]           k_value,
    input  logic [FRAC_BITS+6:0]           d_value,
    input  logic signed [FRAC_BITS+9:0]    j_value,
    input  logic                           cfg_write,
    input  logic [kdj_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kdj_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             pending,
    output int                             compared
);
    import kdj_pkg::*;

    localparam int LINE_W = FRAC_BITS + 7;
    localparam int J_W = FRAC_BITS + 10;
    localparam logic [LINE_W-1:0] MID_LEVEL = LINE_W'(50) << FRAC_BITS;
    localparam logic [LINE_W-1:0] TOP_LEVEL = LINE_W'(100) << FRAC_BITS;

    typedef struct packed {
        logic [LINE_W-1:0] k;
        logic [LINE_W-1:0] d;
        logic [J_W-1:0]    j;
    } kdj_point_t;

    kdj_point_t kdj_due[$];

    logic [PRICE_BITS-1:0] hist_high [WINDOW_MAX];
    logic [PRICE_BITS-1:0] hist_low [WINDOW_MAX];
    int unsigned ring_pos;
    int unsigned depth;
    logic [LINE_W-1:0] k_track;
    logic [LINE_W-1:0] d_track;
    logic [WLEN_W-1:0] span_cfg;
    logic [SMOOTH_W-1:0] k_div_cfg;
    logic [SMOOTH_W-1:0] d_div_cfg;

    // position of the close inside [lo, hi], 0..100 with FRAC_BITS fraction bits
    function automatic logic [LINE_W-1:0] stoch_level(input logic [PRICE_BITS-1:0] c,
                                                      input logic [PRICE_BITS-1:0] lo,
                                                      input logic [PRICE_BITS-1:0] hi);
        logic [63:0] span;
        logic [63:0] scaled;
        if (hi <= lo)
            return MID_LEVEL;
        if (c <= lo)
            return '0;
        if (c >= hi)
            return TOP_LEVEL;
        span = 64'(hi) - 64'(lo);
        scaled = ((64'(c) - 64'(lo)) * 64'd100) << FRAC_BITS;
        return LINE_W'(scaled / span);
    endfunction

    function automatic logic [LINE_W-1:0] ease(input logic [LINE_W-1:0] prev,
                                               input logic [LINE_W-1:0] x,
                                               input logic [SMOOTH_W-1:0] f);
        logic [63:0] div;
        div = (f == 0) ? 64'd1 : 64'(f);
        return LINE_W'(((div - 1) * 64'(prev) + 64'(x)) / div);
    endfunction

    function automatic kdj_point_t advance_series(input logic new_series,
                                                  input logic [PRICE_BITS-1:0] h,
                                                  input logic [PRICE_BITS-1:0] l,
                                                  input logic [PRICE_BITS-1:0] c);
        int unsigned span_len;
        int unsigned slot;
        int i;
        bit opening;
        logic [PRICE_BITS-1:0] lo;
        logic [PRICE_BITS-1:0] hi;
        logic [LINE_W-1:0] rsv;
        logic [63:0] j_wide;
        kdj_point_t pt;
        if (new_series) begin
            depth = 0;
            ring_pos = 0;
        end
        opening = (depth == 0);
        hist_high[ring_pos] = h;
        hist_low[ring_pos] = l;
        ring_pos = (ring_pos + 1) % WINDOW_MAX;
        if (depth < WINDOW_MAX)
            depth++;

        span_len = (span_cfg == 0) ? 1 : span_cfg;
        if (span_len > WINDOW_MAX)
            span_len = WINDOW_MAX;
        if (span_len > depth)
            span_len = depth;

        lo = l;
        hi = h;
        for (i = 0; i < span_len; i++) begin
            slot = (ring_pos + WINDOW_MAX - 1 - i) % WINDOW_MAX;
            if (hist_low[slot] < lo)
                lo = hist_low[slot];
            if (hist_high[slot] > hi)
                hi = hist_high[slot];
        end

        rsv = stoch_level(c, lo, hi);
        if (opening) begin
            k_track = rsv;
            d_track = rsv;
        end else begin
            k_track = ease(k_track, rsv, k_div_cfg);
            d_track = ease(d_track, k_track, d_div_cfg);
        end
        j_wide = 64'd3 * 64'(k_track) - 64'd2 * 64'(d_track);
        pt.k = k_track;
        pt.d = d_track;
        pt.j = j_wide[J_W-1:0];
        return pt;
    endfunction

    always @(posedge clk) begin : watch
        kdj_point_t got;
        kdj_point_t want;
        if (!rst_n) begin
            kdj_due.delete();
            ring_pos = 0;
            depth = 0;
            k_track = '0;
            d_track = '0;
            span_cfg = WLEN_RESET;
            k_div_cfg = K_SMOOTH_RESET;
            d_div_cfg = D_SMOOTH_RESET;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_WINDOW_LENGTH: span_cfg = cfg_data[WLEN_W-1:0];
                    REG_K_SMOOTHING:   k_div_cfg = cfg_data[SMOOTH_W-1:0];
                    REG_D_SMOOTHING:   d_div_cfg = cfg_data[SMOOTH_W-1:0];
                    default: ;
                endcase
            end

            // results are taken before the same edge's bar so the oldest is compared
            if (out_valid && out_ready) begin
                got.k = k_value;
                got.d = d_value;
                got.j = j_value;
                if (kdj_due.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("[%0t] result with nothing outstanding: k=%0d d=%0d j=%0d",
                                 $realtime, got.k, got.d, $signed(got.j));
                end else begin
                    want = kdj_due.pop_front();
                    compared <= compared + 1;
                    if (got !== want) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("[%0t] mismatch: exp k=%0d d=%0d j=%0d got %0d %0d %0d",
                                     $realtime, want.k, want.d, $signed(want.j),
                                     got.k, got.d, $signed(got.j));
                    end
                end
            end

            if (in_valid && in_ready)
                kdj_due.push_back(advance_series(start_series, price_high, price_low,
                                                 price_close));
        end
        pending <= kdj_due.size();
    end

endmodule

/* tb/tb_top.sv */
// tb_top: stimulus and verdict for stochastic_kdj_oscillator_core
// drives bars and register writes; prediction and comparison live in kdj_checker
`timescale 1ns / 1ps

module tb_top;
    import kdj_pkg::*;

    localparam int WINDOW_MAX = 32;
    localparam int PRICE_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int STALL_LIMIT = 5000;
    localparam int BARS_PER_PHASE = 72;
    localparam int PHASES = 8;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [PRICE_BITS-1:0] PRICE_TOP = {PRICE_BITS{1'b1}};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic start_series = 1'b0;
    logic [PRICE_BITS-1:0] price_high = '0;
    logic [PRICE_BITS-1:0] price_low = '0;
    logic [PRICE_BITS-1:0] price_close = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [FRAC_BITS+6:0] k_value;
    logic [FRAC_BITS+6:0] d_value;
    logic signed [FRAC_BITS+9:0] j_value;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int mismatches;
    int pending;
    int compared;

    bit calm = 1'b0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    int bars_sent = 0;
    int series_opened = 0;
    int settings_written = 0;

    // random walk state for well-formed series
    longint walk_mid = 0;
    int unsigned walk_scale = 1;
    int unsigned bars_left = 0;

    always #5 clk = ~clk;

    stochastic_kdj_oscillator_core #(
        .WINDOW_MAX(WINDOW_MAX),
        .PRICE_BITS(PRICE_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .start_series(start_series),
        .price_high(price_high),
        .price_low(price_low),
        .price_close(price_close),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .k_value(k_value),
        .d_value(d_value),
        .j_value(j_value),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    kdj_checker #(
        .WINDOW_MAX(WINDOW_MAX),
        .PRICE_BITS(PRICE_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .start_series(start_series),
        .price_high(price_high),
        .price_low(price_low),
        .price_close(price_close),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .k_value(k_value),
        .d_value(d_value),
        .j_value(j_value),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatches(mismatches),
        .pending(pending),
        .compared(compared)
    );

    // receiver: short random stalls plus the odd long one
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (!calm && $urandom_range(99) < 11) begin
            out_ready <= 1'b0;
            if ($urandom_range(511) == 0)
                hold_left <= $urandom_range(20, 200);
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("no transfer for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic logic [PRICE_BITS-1:0] clip_price(input longint v);
        if (v < 0)
            return '0;
        if (v > longint'(PRICE_TOP))
            return PRICE_TOP;
        return v[PRICE_BITS-1:0];
    endfunction

    // leaves in_valid high after the transfer so back-to-back bars need no gap
    task automatic send_bar(input bit ss, input logic [PRICE_BITS-1:0] h,
                            input logic [PRICE_BITS-1:0] l, input logic [PRICE_BITS-1:0] c);
        int unsigned gap;
        if (!calm && $urandom_range(99) < 11) begin
            gap = $urandom_range(1, 140);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        start_series <= ss;
        price_high <= h;
        price_low <= l;
        price_close <= c;
        do @(posedge clk); while (!in_ready);
        bars_sent++;
        if (ss)
            series_opened++;
    endtask

    task automatic next_bar(output bit ss, output logic [PRICE_BITS-1:0] h,
                            output logic [PRICE_BITS-1:0] l, output logic [PRICE_BITS-1:0] c);
        longint hi_v;
        longint lo_v;
        longint cl_v;
        ss = 1'b0;
        if (bars_left == 0) begin
            ss = 1'b1;
            bars_left = ($urandom_range(9) == 0) ? $urandom_range(41, 90) : $urandom_range(1, 40);
            case ($urandom_range(3))
                0: walk_scale = $urandom_range(1, 16);
                1: walk_scale = $urandom_range(17, 5000);
                2: walk_scale = $urandom_range(5001, 1 << 20);
                default: walk_scale = $urandom_range(1 << 20, 1 << 30);
            endcase
            walk_mid = longint'($urandom);
        end
        bars_left--;
        if ($urandom_range(99) < 80) begin
            walk_mid = longint'(clip_price(walk_mid
                       + longint'($urandom_range(0, 2 * walk_scale)) - longint'(walk_scale)));
            hi_v = walk_mid + longint'($urandom_range(0, walk_scale));
            lo_v = walk_mid - longint'($urandom_range(0, walk_scale));
            case ($urandom_range(9))
                0: cl_v = lo_v - longint'($urandom_range(0, walk_scale));
                1: cl_v = hi_v + longint'($urandom_range(0, walk_scale));
                default: cl_v = lo_v + longint'($urandom_range(0, 32'(hi_v - lo_v)));
            endcase
            h = clip_price(hi_v);
            l = clip_price(lo_v);
            c = clip_price(cl_v);
        end else begin
            // noise: unrelated fields, often inverted, sometimes flat
            ss = ss | ($urandom_range(15) == 0);
            h = $urandom;
            l = ($urandom_range(3) == 0) ? h : $urandom;
            c = $urandom;
        end
    endtask

    // returns once the checker has nothing outstanding
    task automatic wait_drained();
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        settings_written++;
    endtask

    initial begin : stimulus
        int n;
        int phase;
        bit ss;
        logic [PRICE_BITS-1:0] h;
        logic [PRICE_BITS-1:0] l;
        logic [PRICE_BITS-1:0] c;
        logic [CFG_DATA_W-1:0] wl;
        logic [CFG_DATA_W-1:0] kd;
        logic [CFG_DATA_W-1:0] dd;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed bars at the reset settings (window 9, smoothing 3 and 3)
        send_bar(1'b0, 1000, 900, 950);      // first bar after reset, no start flag
        send_bar(1'b0, 1010, 950, 800);      // close under the window low
        send_bar(1'b0, 1020, 960, 5000);     // close over the window high
        send_bar(1'b0, 1005, 900, 900);      // close right on the low
        send_bar(1'b0, 1020, 980, 1020);     // close right on the high
        send_bar(1'b1, 500, 500, 500);       // new series, flat window
        send_bar(1'b0, 500, 500, 0);
        send_bar(1'b1, 100, 200, 150);       // inverted bar
        send_bar(1'b0, 90, 300, 95);         // window stays inverted
        send_bar(1'b1, PRICE_TOP, '0, PRICE_TOP - 1);
        send_bar(1'b0, PRICE_TOP, '0, 1);
        send_bar(1'b0, '0, PRICE_TOP, PRICE_TOP);
        send_bar(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        // longer than the window so the oldest low drops out
        for (n = 0; n < 12; n++)
            send_bar(n == 0, 3000 - 40 * n, 2000 + 30 * n, 2500);

        for (phase = 0; phase < PHASES; phase++) begin
            in_valid <= 1'b0;
            wait_drained();
            case (phase)
                0: begin wl = 8'd1;   kd = 8'd1;   dd = 8'd1;   end
                1: begin wl = 8'd32;  kd = 8'd255; dd = 8'd255; end
                2: begin wl = 8'd0;   kd = 8'd0;   dd = 8'd0;   end
                3: begin wl = 8'd63;  kd = 8'd5;   dd = 8'd2;   end
                4: begin wl = 8'hC5;  kd = 8'd14;  dd = 8'd9;   end
                5: begin wl = 8'd40;  kd = 8'd2;   dd = 8'd200; end
                6: begin wl = 8'd12;  kd = 8'd255; dd = 8'd1;   end
                default: begin wl = 8'd1; kd = 8'd0; dd = 8'd255; end
            endcase
            write_reg(REG_WINDOW_LENGTH, wl);
            write_reg(REG_K_SMOOTHING, kd);
            write_reg(REG_D_SMOOTHING, dd);
            if (phase == 2)
                write_reg(REG_UNUSED, 8'($urandom));
            cfg_write <= 1'b0;
            calm <= (phase == 3);
            for (n = 0; n < BARS_PER_PHASE; n++) begin
                next_bar(ss, h, l, c);
                send_bar(ss, h, l, c);
            end
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (130) @(posedge clk);

        $display("covered %0d bars in %0d explicit series starts, %0d register writes",
                 bars_sent, series_opened, settings_written);
        $display("%0d results compared, %0d mismatches", compared, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
